### src/assert_macros.svh
// Assertion macros used by the RTL of the JSON scalar validator.
// No dependencies; the bodies fall away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Invariant that holds on every cycle outside reset.
`define CHK_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`else

`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg)
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg)
`define CHK_ALWAYS(lbl, clk, rst, cond, msg)

`endif

`endif

### src/jsv_pkg.sv
// Types, codes and character helpers for the JSON scalar validator.
// No dependencies; imported by json_scalar_validator_top.
package jsv_pkg;

  // Longest text accepted; the byte counter saturates here.
  localparam int unsigned MAX_TEXT = 4096;
  localparam int unsigned POS_W    = 13;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TEXT);

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EXPECT = 2'd1;
  localparam logic [1:0] ST_INVAL  = 2'd2;
  localparam logic [1:0] ST_SINGLE = 2'd3;

  // Value kinds.
  localparam logic [1:0] KIND_NULL   = 2'd0;
  localparam logic [1:0] KIND_FALSE  = 2'd1;
  localparam logic [1:0] KIND_TRUE   = 2'd2;
  localparam logic [1:0] KIND_NUMBER = 2'd3;

  typedef enum logic [3:0] {
    PH_LEAD   = 4'd0,
    PH_LIT    = 4'd1,
    PH_NSIGN  = 4'd2,
    PH_NZERO  = 4'd3,
    PH_NINT   = 4'd4,
    PH_NDOT   = 4'd5,
    PH_NFRAC  = 4'd6,
    PH_NE     = 4'd7,
    PH_NESIGN = 4'd8,
    PH_NEXP   = 4'd9,
    PH_TRAIL  = 4'd10
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  value_kind;
    logic [11:0] token_start;
    logic [12:0] token_length;
  } out_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_exp_mark(input logic [7:0] c);
    return (c == 8'h65) || (c == 8'h45);
  endfunction

  // Characters of null, false and true, indexed by kind and position.
  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (kind)
      KIND_FALSE: begin
        case (idx)
          3'd0: ch = 8'h66;
          3'd1: ch = 8'h61;
          3'd2: ch = 8'h6C;
          3'd3: ch = 8'h73;
          3'd4: ch = 8'h65;
          default: ch = 8'h65;
        endcase
      end
      KIND_TRUE: begin
        case (idx)
          3'd0: ch = 8'h74;
          3'd1: ch = 8'h72;
          3'd2: ch = 8'h75;
          3'd3: ch = 8'h65;
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          3'd0: ch = 8'h6E;
          3'd1: ch = 8'h75;
          3'd2: ch = 8'h6C;
          3'd3: ch = 8'h6C;
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    return (kind == KIND_FALSE) ? 3'd5 : 3'd4;
  endfunction

endpackage

### src/json_scalar_validator_top.sv
// An end-of-text transaction waits in the input register until it fires; its result is then
// loaded into the result register, from which it can be taken.
// Throughput: one transaction per cycle; only an end-of-text transaction stalls the input,
// and only while the result register still holds a verdict that has not been taken.
// Reset (rst, synchronous, active high) empties both registers and clears the scanner.
// Depends on jsv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module json_scalar_validator_top
  import jsv_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Input register. A text byte never produces a result, so it always moves
  // on; only an end-of-text transaction waits for room in the result register.
  logic stage_valid;
  in_t  stage;
  logic fire;

  // Scanner state.
  phase_t            phase, phase_next;
  logic [1:0]        literal_kind, literal_kind_next;
  logic [2:0]        literal_pos, literal_pos_next;
  logic [POS_W-1:0]  position, position_next;
  logic [11:0]       scalar_begin, scalar_begin_next;
  logic [POS_W-1:0]  scalar_end, scalar_end_next;
  logic [1:0]        latched_error, latched_error_next;

  out_t result;
  logic [7:0] c;

  assign c        = stage.text_byte;
  assign fire     = stage_valid && (!stage.end_of_text || !out_valid || out_ready);
  assign in_ready = !stage_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage <= in_data;
    end
  end

  // Next-state logic: one scanner step for the byte in the input register.
  always_comb begin
    phase_next         = phase;
    literal_kind_next  = literal_kind;
    literal_pos_next   = literal_pos;
    position_next      = position;
    scalar_begin_next  = scalar_begin;
    scalar_end_next    = scalar_end;
    latched_error_next = latched_error;

    if (stage.end_of_text) begin
      // The terminator closes the text; the next transaction starts afresh.
      phase_next         = PH_LEAD;
      literal_kind_next  = KIND_NULL;
      literal_pos_next   = 3'd0;
      position_next      = '0;
      scalar_begin_next  = '0;
      scalar_end_next    = '0;
      latched_error_next = ST_OK;
    end else begin
      if (latched_error == ST_OK) begin
        if (position >= MAX_POS) begin
          latched_error_next = ST_INVAL;
        end else begin
          unique case (phase)
            PH_LEAD: begin
              if (!is_blank(c)) begin
                scalar_begin_next = position[11:0];
                if (c == 8'h6E || c == 8'h66 || c == 8'h74) begin
                  literal_kind_next = (c == 8'h6E) ? KIND_NULL :
                                      (c == 8'h66) ? KIND_FALSE : KIND_TRUE;
                  literal_pos_next  = 3'd1;
                  phase_next        = PH_LIT;
                end else begin
                  literal_kind_next = KIND_NUMBER;
                  if (c == 8'h2D) phase_next = PH_NSIGN;
                  else if (c == 8'h30) phase_next = PH_NZERO;
                  else if (is_digit(c)) phase_next = PH_NINT;
                  else latched_error_next = ST_INVAL;
                end
              end
            end
            PH_LIT: begin
              if (c != lit_char(literal_kind, literal_pos)) begin
                latched_error_next = ST_INVAL;
              end else begin
                literal_pos_next = literal_pos + 3'd1;
                if ((literal_pos + 3'd1) >= lit_len(literal_kind)) begin
                  scalar_end_next = position + POS_W'(1);
                  phase_next      = PH_TRAIL;
                end
              end
            end
            PH_NSIGN: begin
              if (c == 8'h30) phase_next = PH_NZERO;
              else if (is_digit(c)) phase_next = PH_NINT;
              else latched_error_next = ST_INVAL;
            end
            PH_NZERO, PH_NINT: begin
              if (phase == PH_NINT && is_digit(c)) begin
                phase_next = PH_NINT;
              end else if (c == 8'h2E) begin
                phase_next = PH_NDOT;
              end else if (is_exp_mark(c)) begin
                phase_next = PH_NE;
              end else begin
                scalar_end_next = position;
                phase_next      = PH_TRAIL;
                if (!is_blank(c)) latched_error_next = ST_SINGLE;
              end
            end
            PH_NDOT: begin
              if (is_digit(c)) phase_next = PH_NFRAC;
              else latched_error_next = ST_INVAL;
            end
            PH_NFRAC: begin
              if (is_digit(c)) begin
                phase_next = PH_NFRAC;
              end else if (is_exp_mark(c)) begin
                phase_next = PH_NE;
              end else begin
                scalar_end_next = position;
                phase_next      = PH_TRAIL;
                if (!is_blank(c)) latched_error_next = ST_SINGLE;
              end
            end
            PH_NE: begin
              if (c == 8'h2B || c == 8'h2D) phase_next = PH_NESIGN;
              else if (is_digit(c)) phase_next = PH_NEXP;
              else latched_error_next = ST_INVAL;
            end
            PH_NESIGN: begin
              if (is_digit(c)) phase_next = PH_NEXP;
              else latched_error_next = ST_INVAL;
            end
            PH_NEXP: begin
              if (!is_digit(c)) begin
                scalar_end_next = position;
                phase_next      = PH_TRAIL;
                if (!is_blank(c)) latched_error_next = ST_SINGLE;
              end
            end
            PH_TRAIL: begin
              if (!is_blank(c)) latched_error_next = ST_SINGLE;
            end
            default: begin
              latched_error_next = ST_INVAL;
            end
          endcase
        end
      end
      // The byte counter saturates at the text limit.
      if (position < MAX_POS) position_next = position + POS_W'(1);
    end
  end

  // Output logic: the result that the terminator would produce from the
  // present state. An unfinished number is closed at the current position.
  always_comb begin
    logic [1:0]       st;
    logic [POS_W-1:0] end_pos;
    logic [POS_W-1:0] begin_pos;
    st        = latched_error;
    end_pos   = scalar_end;
    begin_pos = {1'b0, scalar_begin};
    if (latched_error == ST_OK) begin
      unique case (phase) inside
        PH_LEAD: st = ST_EXPECT;
        PH_NZERO, PH_NINT, PH_NFRAC, PH_NEXP: begin
          st      = ST_OK;
          end_pos = position;
        end
        PH_TRAIL: st = ST_OK;
        default:  st = ST_INVAL;
      endcase
    end
    result.status = st;
    if (st == ST_OK) begin
      result.value_kind   = literal_kind;
      result.token_start  = scalar_begin;
      result.token_length = (end_pos >= begin_pos) ? (end_pos - begin_pos) : '0;
    end else begin
      result.value_kind   = KIND_NULL;
      result.token_start  = '0;
      result.token_length = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      literal_kind  <= KIND_NULL;
      literal_pos   <= 3'd0;
      position      <= '0;
      scalar_begin  <= '0;
      scalar_end    <= '0;
      latched_error <= ST_OK;
    end else if (fire) begin
      phase         <= phase_next;
      literal_kind  <= literal_kind_next;
      literal_pos   <= literal_pos_next;
      position      <= position_next;
      scalar_begin  <= scalar_begin_next;
      scalar_end    <= scalar_end_next;
      latched_error <= latched_error_next;
    end
  end

  // Result register: loaded by an end-of-text transaction, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && stage.end_of_text) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && stage.end_of_text) begin
      out_data <= result;
    end
  end

  // A failed text reports no token.
  `CHK_IMPLY(a_err_fields_zero, clk, rst,
    out_valid && out_data.status != ST_OK,
    out_data.value_kind == KIND_NULL && out_data.token_start == '0 &&
    out_data.token_length == '0,
    "error result carries token fields")
  // A literal is always four or five bytes long.
  `CHK_IMPLY(a_lit_length, clk, rst,
    out_valid && out_data.status == ST_OK && out_data.value_kind != KIND_NUMBER,
    out_data.token_length == 13'd4 || out_data.token_length == 13'd5,
    "literal token of wrong length")
  // After a terminator the scanner is back at the start of a text.
  `CHK_NEXT(a_restart, clk, rst, fire && stage.end_of_text,
    phase == PH_LEAD && position == '0 && latched_error == ST_OK,
    "scanner not cleared after end of text")
  // The byte counter never passes the text limit.
  `CHK_ALWAYS(a_pos_limit, clk, rst, position <= MAX_POS, "byte counter beyond text limit")

endmodule
